// ===== rtl/core/mad_pkg.sv =====
// Shared constants, types and register codes of the motion adaptive deinterlacer.
// Used by mad_filter and motion_adaptive_deinterlace_pixel.
package mad_pkg;

    localparam int LANE_W         = 16;
    localparam int PIXEL_BITS_DEF = 16;
    localparam int COEF_W         = 14;
    localparam int PEAK_W         = 16;
    localparam int COEF_SHIFT     = 13;
    localparam int CFG_IDX_W      = 3;
    localparam int CFG_DATA_W     = 16;

    localparam logic [PEAK_W-1:0] PEAK_RST      = PEAK_W'(255);
    localparam logic [COEF_W-1:0] LF_NEAR_RST   = COEF_W'(4309);
    localparam logic [COEF_W-1:0] LF_FAR_RST    = COEF_W'(213);
    localparam logic [COEF_W-1:0] HF_CENTER_RST = COEF_W'(5570);
    localparam logic [COEF_W-1:0] HF_TWO_RST    = COEF_W'(3801);
    localparam logic [COEF_W-1:0] HF_FOUR_RST   = COEF_W'(1016);
    localparam logic [COEF_W-1:0] SP_NEAR_RST   = COEF_W'(5077);
    localparam logic [COEF_W-1:0] SP_FAR_RST    = COEF_W'(981);

    typedef enum logic [CFG_IDX_W-1:0] {
        REG_PEAK      = 3'd0,
        REG_LF_NEAR   = 3'd1,
        REG_LF_FAR    = 3'd2,
        REG_HF_CENTER = 3'd3,
        REG_HF_TWO    = 3'd4,
        REG_HF_FOUR   = 3'd5,
        REG_SP_NEAR   = 3'd6,
        REG_SP_FAR    = 3'd7
    } cfg_reg_t;

    typedef enum logic [1:0] {
        ROW_INTERIOR   = 2'd0,
        ROW_EDGE_CHECK = 2'd1,
        ROW_EDGE_PLAIN = 2'd2
    } row_kind_t;

    typedef struct packed {
        logic [COEF_W-1:0] lf_near;
        logic [COEF_W-1:0] lf_far;
        logic [COEF_W-1:0] hf_center;
        logic [COEF_W-1:0] hf_two;
        logic [COEF_W-1:0] hf_four;
        logic [COEF_W-1:0] sp_near;
        logic [COEF_W-1:0] sp_far;
    } coef_t;

endpackage

// ===== rtl/core/motion_adaptive_deinterlace_pixel.sv =====
// Top level of the motion adaptive deinterlacer: config registers, tap unpack,
// difference path and final clamp. Depends on mad_pkg and mad_filter.
// The start beat passes the stage valid registers s1 to s4 and then the out_valid register.
// Throughput: one beat per cycle; busy is never raised, results cannot be stalled.
// Reset: clears all stage valid bits and loads the default peak and coefficients.
module motion_adaptive_deinterlace_pixel
    import mad_pkg::*;
#(
    parameter int PIXEL_BITS = PIXEL_BITS_DEF
)
(
    input  logic                  clk,
    input  logic                  rst_n,
    input  logic                  start,
    output logic                  busy,
    input  logic [4*LANE_W-1:0]   prev2_far_rows,
    input  logic [4*LANE_W-1:0]   next2_far_rows,
    input  logic [LANE_W-1:0]     prev2_center,
    input  logic [LANE_W-1:0]     next2_center,
    input  logic [2*LANE_W-1:0]   prev_pair,
    input  logic [2*LANE_W-1:0]   next_pair,
    input  logic [4*LANE_W-1:0]   cur_rows,
    input  logic [LANE_W-1:0]     edge_pixel,
    input  logic                  use_edge_pixel,
    input  logic [1:0]            row_kind,
    output logic                  out_valid,
    output logic [LANE_W-1:0]     out_pixel,
    input  logic                  cfg_valid,
    output logic                  cfg_ready,
    input  logic [CFG_IDX_W-1:0]  cfg_index,
    input  logic [CFG_DATA_W-1:0] cfg_data
);

    localparam int P  = PIXEL_BITS;
    localparam int SW = P + 2;
    localparam int FW = P + 19 - COEF_SHIFT;
    localparam int IW = P + 10;
    localparam logic [PEAK_W-1:0] PIX_MAX = PEAK_W'((1 << P) - 1);

    typedef struct packed {
        logic [P-1:0]         d;
        logic signed [SW-1:0] diff;
        logic                 tzero;
        logic                 interior;
        logic                 gt;
        logic                 use_edge;
        logic [P-1:0]         edge_pix;
        logic [P-1:0]         avg_ce;
    } side_t;

    function automatic logic [P-1:0] absd(input logic [P-1:0] a, input logic [P-1:0] b);
        absd = (a >= b) ? (a - b) : (b - a);
    endfunction

    function automatic logic signed [SW-1:0] smax(input logic signed [SW-1:0] a,
                                                  input logic signed [SW-1:0] b);
        smax = (a > b) ? a : b;
    endfunction

    function automatic logic signed [SW-1:0] smin(input logic signed [SW-1:0] a,
                                                  input logic signed [SW-1:0] b);
        smin = (a < b) ? a : b;
    endfunction

    // configuration
    logic [PEAK_W-1:0] peak_reg;
    coef_t             coef_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            peak_reg           <= PEAK_RST;
            coef_reg.lf_near   <= LF_NEAR_RST;
            coef_reg.lf_far    <= LF_FAR_RST;
            coef_reg.hf_center <= HF_CENTER_RST;
            coef_reg.hf_two    <= HF_TWO_RST;
            coef_reg.hf_four   <= HF_FOUR_RST;
            coef_reg.sp_near   <= SP_NEAR_RST;
            coef_reg.sp_far    <= SP_FAR_RST;
        end
        else if (cfg_valid && cfg_ready)
        begin
            case (cfg_reg_t'(cfg_index))
                REG_PEAK:      peak_reg           <= cfg_data[PEAK_W-1:0];
                REG_LF_NEAR:   coef_reg.lf_near   <= cfg_data[COEF_W-1:0];
                REG_LF_FAR:    coef_reg.lf_far    <= cfg_data[COEF_W-1:0];
                REG_HF_CENTER: coef_reg.hf_center <= cfg_data[COEF_W-1:0];
                REG_HF_TWO:    coef_reg.hf_two    <= cfg_data[COEF_W-1:0];
                REG_HF_FOUR:   coef_reg.hf_four   <= cfg_data[COEF_W-1:0];
                REG_SP_NEAR:   coef_reg.sp_near   <= cfg_data[COEF_W-1:0];
                REG_SP_FAR:    coef_reg.sp_far    <= cfg_data[COEF_W-1:0];
                default:       peak_reg           <= peak_reg;
            endcase
        end
    end

    assign cfg_ready = 1'b1;
    assign busy      = 1'b0;

    // stage 1: unpack taps, first sums and differences
    logic [P-1:0] p2c, n2c, c, e, c3, e3;
    logic [P-1:0] p2a2, p2b2, n2a2, n2b2, p2a4, p2b4, n2a4, n2b4;
    logic [P-1:0] pa, pb, na, nb;
    logic [P:0]   sum_c_next, sum_near_next, sum_far_next, td1_sum, td2_sum;
    logic [P:0]   a2_sum, b2_sum;
    logic [P+1:0] sum_two_next, sum_four_next;
    logic [P-1:0] d_next, td0_next, td1_next, td2_next;
    logic signed [SW-1:0] b_next, f_next, dc_next, de_next;
    logic         gt_next;

    always_comb
    begin
        p2c  = prev2_center[P-1:0];
        n2c  = next2_center[P-1:0];
        c3   = cur_rows[0*LANE_W +: P];
        c    = cur_rows[1*LANE_W +: P];
        e    = cur_rows[2*LANE_W +: P];
        e3   = cur_rows[3*LANE_W +: P];
        p2a4 = prev2_far_rows[0*LANE_W +: P];
        p2a2 = prev2_far_rows[1*LANE_W +: P];
        p2b2 = prev2_far_rows[2*LANE_W +: P];
        p2b4 = prev2_far_rows[3*LANE_W +: P];
        n2a4 = next2_far_rows[0*LANE_W +: P];
        n2a2 = next2_far_rows[1*LANE_W +: P];
        n2b2 = next2_far_rows[2*LANE_W +: P];
        n2b4 = next2_far_rows[3*LANE_W +: P];
        pa   = prev_pair[0 +: P];
        pb   = prev_pair[LANE_W +: P];
        na   = next_pair[0 +: P];
        nb   = next_pair[LANE_W +: P];

        sum_c_next    = {1'b0, p2c} + {1'b0, n2c};
        sum_near_next = {1'b0, c} + {1'b0, e};
        sum_far_next  = {1'b0, c3} + {1'b0, e3};
        a2_sum        = {1'b0, p2a2} + {1'b0, n2a2};
        b2_sum        = {1'b0, p2b2} + {1'b0, n2b2};
        sum_two_next  = {1'b0, a2_sum} + {1'b0, b2_sum};
        sum_four_next = ({2'b0, p2a4} + {2'b0, n2a4}) + ({2'b0, p2b4} + {2'b0, n2b4});

        d_next   = sum_c_next[P:1];
        td0_next = absd(p2c, n2c);
        td1_sum  = {1'b0, absd(pa, c)} + {1'b0, absd(pb, e)};
        td2_sum  = {1'b0, absd(na, c)} + {1'b0, absd(nb, e)};
        td1_next = td1_sum[P:1];
        td2_next = td2_sum[P:1];

        b_next  = signed'({2'b0, a2_sum[P:1]}) - signed'({2'b0, c});
        f_next  = signed'({2'b0, b2_sum[P:1]}) - signed'({2'b0, e});
        dc_next = signed'({2'b0, d_next}) - signed'({2'b0, c});
        de_next = signed'({2'b0, d_next}) - signed'({2'b0, e});
        gt_next = absd(c, e) > td0_next;
    end

    logic                 s1_valid_reg;
    logic [P:0]           s1_sum_c_reg, s1_sum_near_reg, s1_sum_far_reg;
    logic [P+1:0]         s1_sum_two_reg, s1_sum_four_reg;
    logic [P-1:0]         s1_d_reg, s1_td0_reg, s1_td1_reg, s1_td2_reg;
    logic signed [SW-1:0] s1_b_reg, s1_f_reg, s1_dc_reg, s1_de_reg;
    logic                 s1_gt_reg, s1_use_edge_reg;
    logic [1:0]           s1_kind_reg;
    logic [P-1:0]         s1_edge_reg;

    always_ff @(posedge clk)
    begin
        s1_sum_c_reg    <= sum_c_next;
        s1_sum_near_reg <= sum_near_next;
        s1_sum_far_reg  <= sum_far_next;
        s1_sum_two_reg  <= sum_two_next;
        s1_sum_four_reg <= sum_four_next;
        s1_d_reg        <= d_next;
        s1_td0_reg      <= td0_next;
        s1_td1_reg      <= td1_next;
        s1_td2_reg      <= td2_next;
        s1_b_reg        <= b_next;
        s1_f_reg        <= f_next;
        s1_dc_reg       <= dc_next;
        s1_de_reg       <= de_next;
        s1_gt_reg       <= gt_next;
        s1_use_edge_reg <= use_edge_pixel;
        s1_kind_reg     <= row_kind;
        s1_edge_reg     <= edge_pixel[P-1:0];
    end

    // stage 2: temporal difference and spatial check
    logic [P-1:0]         tdiff;
    logic signed [SW-1:0] tdiff_s, mx, mn, diff_chk;
    logic                 check;
    side_t                s2_side_next;

    always_comb
    begin
        tdiff = s1_td0_reg >> 1;
        if (s1_td1_reg > tdiff)
            tdiff = s1_td1_reg;
        if (s1_td2_reg > tdiff)
            tdiff = s1_td2_reg;
        tdiff_s  = signed'({2'b0, tdiff});
        mx       = smax(smax(s1_de_reg, s1_dc_reg), smin(s1_b_reg, s1_f_reg));
        mn       = smin(smin(s1_de_reg, s1_dc_reg), smax(s1_b_reg, s1_f_reg));
        diff_chk = smax(smax(tdiff_s, mn), -mx);
        check    = (s1_kind_reg == ROW_INTERIOR) || (s1_kind_reg == ROW_EDGE_CHECK);

        s2_side_next.d        = s1_d_reg;
        s2_side_next.diff     = check ? diff_chk : tdiff_s;
        s2_side_next.tzero    = (tdiff == '0);
        s2_side_next.interior = (s1_kind_reg == ROW_INTERIOR);
        s2_side_next.gt       = s1_gt_reg;
        s2_side_next.use_edge = s1_use_edge_reg;
        s2_side_next.edge_pix = s1_edge_reg;
        s2_side_next.avg_ce   = s1_sum_near_reg[P:1];
    end

    side_t s2_side_reg, s3_side_reg, s4_side_reg;
    logic  s2_valid_reg, s3_valid_reg, s4_valid_reg;

    always_ff @(posedge clk)
    begin
        s2_side_reg <= s2_side_next;
        s3_side_reg <= s2_side_reg;
        s4_side_reg <= s3_side_reg;
    end

    // stages 2 to 4: weighted sums
    logic signed [FW-1:0] cubic, spatial;

    mad_filter #(
        .PIXEL_BITS (PIXEL_BITS)
    ) u_filter (
        .clk      (clk),
        .coef     (coef_reg),
        .sum_c    (s1_sum_c_reg),
        .sum_two  (s1_sum_two_reg),
        .sum_four (s1_sum_four_reg),
        .sum_near (s1_sum_near_reg),
        .sum_far  (s1_sum_far_reg),
        .cubic    (cubic),
        .spatial  (spatial)
    );

    // stage 5: select, clamp to d +/- diff, saturate
    logic signed [IW-1:0] interp, lo, hi, d_s, diff_s, lim_s;
    logic [PEAK_W-1:0]    lim;
    logic [LANE_W-1:0]    out_pixel_next;

    always_comb
    begin
        if (s4_side_reg.use_edge)
            interp = signed'(IW'(s4_side_reg.edge_pix));
        else if (!s4_side_reg.interior)
            interp = signed'(IW'(s4_side_reg.avg_ce));
        else if (s4_side_reg.gt)
            interp = IW'(cubic);
        else
            interp = IW'(spatial);

        d_s    = signed'(IW'(s4_side_reg.d));
        diff_s = IW'(s4_side_reg.diff);
        lo     = d_s - diff_s;
        hi     = d_s + diff_s;
        if (interp < lo)
            interp = lo;
        if (interp > hi)
            interp = hi;
        if (s4_side_reg.tzero)
            interp = d_s;

        lim   = (peak_reg > PIX_MAX) ? PIX_MAX : peak_reg;
        lim_s = signed'(IW'(lim));
        if (interp < 0)
            interp = '0;
        if (interp > lim_s)
            interp = lim_s;
        out_pixel_next = interp[LANE_W-1:0];
    end

    logic              out_valid_reg;
    logic [LANE_W-1:0] out_pixel_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            s1_valid_reg  <= 1'b0;
            s2_valid_reg  <= 1'b0;
            s3_valid_reg  <= 1'b0;
            s4_valid_reg  <= 1'b0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            s1_valid_reg  <= start && !busy;
            s2_valid_reg  <= s1_valid_reg;
            s3_valid_reg  <= s2_valid_reg;
            s4_valid_reg  <= s3_valid_reg;
            out_valid_reg <= s4_valid_reg;
        end
    end

    always_ff @(posedge clk)
    begin
        out_pixel_reg <= out_pixel_next;
    end

    assign out_valid = out_valid_reg;
    assign out_pixel = out_pixel_reg;

endmodule

// ===== rtl/core/mad_filter.sv =====
// Three-stage weighted-sum filter: cubic spatial-temporal and spatial-only candidates.
// Depends on mad_pkg (coef_t, COEF_SHIFT).
module mad_filter
    import mad_pkg::*;
#(
    parameter int PIXEL_BITS = PIXEL_BITS_DEF
)
(
    input  logic                                     clk,
    input  coef_t                                    coef,
    input  logic [PIXEL_BITS:0]                      sum_c,
    input  logic [PIXEL_BITS+1:0]                    sum_two,
    input  logic [PIXEL_BITS+1:0]                    sum_four,
    input  logic [PIXEL_BITS:0]                      sum_near,
    input  logic [PIXEL_BITS:0]                      sum_far,
    output logic signed [PIXEL_BITS+18-COEF_SHIFT:0] cubic,
    output logic signed [PIXEL_BITS+18-COEF_SHIFT:0] spatial
);

    localparam int PA = PIXEL_BITS + 15;
    localparam int PB = PIXEL_BITS + 16;
    localparam int HW = PIXEL_BITS + 19;
    localparam int OW = HW - COEF_SHIFT;

    logic [PA-1:0] p_hc_reg, p_ln_reg, p_lf_reg, p_sn_reg, p_sf_reg;
    logic [PB-1:0] p_h2_reg, p_h4_reg;
    logic [PA-1:0] p_hc_next, p_ln_next, p_lf_next, p_sn_next, p_sf_next;
    logic [PB-1:0] p_h2_next, p_h4_next;

    logic signed [HW-1:0] hf_reg, lf_reg, sp_reg;
    logic signed [HW-1:0] hf_next, lf_next, sp_next;
    logic signed [HW-1:0] acc;

    logic signed [OW-1:0] cubic_reg, spatial_reg;
    logic signed [OW-1:0] cubic_next, spatial_next;

    always_comb
    begin
        p_hc_next = PA'(coef.hf_center) * PA'(sum_c);
        p_h2_next = PB'(coef.hf_two) * PB'(sum_two);
        p_h4_next = PB'(coef.hf_four) * PB'(sum_four);
        p_ln_next = PA'(coef.lf_near) * PA'(sum_near);
        p_lf_next = PA'(coef.lf_far) * PA'(sum_far);
        p_sn_next = PA'(coef.sp_near) * PA'(sum_near);
        p_sf_next = PA'(coef.sp_far) * PA'(sum_far);
    end

    always_comb
    begin
        hf_next = signed'(HW'(p_hc_reg)) - signed'(HW'(p_h2_reg)) + signed'(HW'(p_h4_reg));
        lf_next = signed'(HW'(p_ln_reg)) - signed'(HW'(p_lf_reg));
        sp_next = signed'(HW'(p_sn_reg)) - signed'(HW'(p_sf_reg));
    end

    always_comb
    begin
        acc          = (hf_reg >>> 2) + lf_reg;
        cubic_next   = acc[HW-1:COEF_SHIFT];
        spatial_next = sp_reg[HW-1:COEF_SHIFT];
    end

    always_ff @(posedge clk)
    begin
        p_hc_reg    <= p_hc_next;
        p_h2_reg    <= p_h2_next;
        p_h4_reg    <= p_h4_next;
        p_ln_reg    <= p_ln_next;
        p_lf_reg    <= p_lf_next;
        p_sn_reg    <= p_sn_next;
        p_sf_reg    <= p_sf_next;
        hf_reg      <= hf_next;
        lf_reg      <= lf_next;
        sp_reg      <= sp_next;
        cubic_reg   <= cubic_next;
        spatial_reg <= spatial_next;
    end

    assign cubic   = cubic_reg;
    assign spatial = spatial_reg;

endmodule

// ===== test/tb_top.sv =====
// Self-checking bench for motion_adaptive_deinterlace_pixel: tap columns in, one pixel out.
// Drives directed and random columns under several register settings and checks each
// pixel against an in-bench prediction. Depends on mad_pkg and the deinterlacer RTL.
module tb_top
    import mad_pkg::*;
();

    timeunit 1ns;
    timeprecision 1ps;

    localparam int PHASE_COLUMNS = 150;
    localparam int SETTLE_CYCLES = 8;
    localparam int DRAIN_LIMIT   = 200;
    localparam int LIMIT_NS      = 1_000_000;

    typedef struct {
        logic [4*LANE_W-1:0] p2_far;
        logic [4*LANE_W-1:0] n2_far;
        logic [LANE_W-1:0]   p2_c;
        logic [LANE_W-1:0]   n2_c;
        logic [2*LANE_W-1:0] prv;
        logic [2*LANE_W-1:0] nxt;
        logic [4*LANE_W-1:0] cur;
        logic [LANE_W-1:0]   edge_px;
        logic                use_edge;
        logic [1:0]          kind;
    } tap_column_t;

    logic                  clk = 1'b0;
    logic                  rst_n = 1'b0;
    logic                  start = 1'b0;
    logic                  busy;
    logic [4*LANE_W-1:0]   prev2_far_rows = '0;
    logic [4*LANE_W-1:0]   next2_far_rows = '0;
    logic [LANE_W-1:0]     prev2_center = '0;
    logic [LANE_W-1:0]     next2_center = '0;
    logic [2*LANE_W-1:0]   prev_pair = '0;
    logic [2*LANE_W-1:0]   next_pair = '0;
    logic [4*LANE_W-1:0]   cur_rows = '0;
    logic [LANE_W-1:0]     edge_pixel = '0;
    logic                  use_edge_pixel = 1'b0;
    logic [1:0]            row_kind = '0;
    logic                  out_valid;
    logic [LANE_W-1:0]     out_pixel;
    logic                  cfg_valid = 1'b0;
    logic                  cfg_ready;
    logic [CFG_IDX_W-1:0]  cfg_index = '0;
    logic [CFG_DATA_W-1:0] cfg_data = '0;

    logic [PEAK_W-1:0]     peak_reg;
    coef_t                 coefs;
    tap_column_t           column_queue[$];
    tap_column_t           column_on_bus;
    logic [LANE_W-1:0]     expected_pixels[$];
    logic [LANE_W-1:0]     want;
    bit                    beat_taken = 1'b0;
    int                    send_idle_pct = 21;
    int                    errors = 0;
    int                    columns_sent = 0;
    int                    pixels_checked = 0;
    int                    settings_used = 1;

    motion_adaptive_deinterlace_pixel dut (
        .clk            (clk),
        .rst_n          (rst_n),
        .start          (start),
        .busy           (busy),
        .prev2_far_rows (prev2_far_rows),
        .next2_far_rows (next2_far_rows),
        .prev2_center   (prev2_center),
        .next2_center   (next2_center),
        .prev_pair      (prev_pair),
        .next_pair      (next_pair),
        .cur_rows       (cur_rows),
        .edge_pixel     (edge_pixel),
        .use_edge_pixel (use_edge_pixel),
        .row_kind       (row_kind),
        .out_valid      (out_valid),
        .out_pixel      (out_pixel),
        .cfg_valid      (cfg_valid),
        .cfg_ready      (cfg_ready),
        .cfg_index      (cfg_index),
        .cfg_data       (cfg_data)
    );

    always
    begin
        #5 clk = 1'b1;
        #5 clk = 1'b0;
    end

    task automatic report_mismatch(input string msg);
        errors++;
        $display("MISMATCH @%0t: %s", $realtime, msg);
    endtask

    function automatic longint magnitude(input longint v);
        return (v < 0) ? -v : v;
    endfunction

    function automatic longint larger(input longint a, input longint b);
        return (a > b) ? a : b;
    endfunction

    function automatic longint smaller(input longint a, input longint b);
        return (a < b) ? a : b;
    endfunction

    function automatic logic [LANE_W-1:0] predict_pixel(input tap_column_t t);
        longint c, e, c3, e3, pc, nc, pa2, pb2, na2, nb2, pa4, pb4, na4, nb4;
        longint avg, td0, td1, td2, tdiff, spread, interp, bgap, fgap, dc, de, hf, acc;
        c3  = longint'(t.cur[15:0]);
        c   = longint'(t.cur[31:16]);
        e   = longint'(t.cur[47:32]);
        e3  = longint'(t.cur[63:48]);
        pa4 = longint'(t.p2_far[15:0]);
        pa2 = longint'(t.p2_far[31:16]);
        pb2 = longint'(t.p2_far[47:32]);
        pb4 = longint'(t.p2_far[63:48]);
        na4 = longint'(t.n2_far[15:0]);
        na2 = longint'(t.n2_far[31:16]);
        nb2 = longint'(t.n2_far[47:32]);
        nb4 = longint'(t.n2_far[63:48]);
        pc  = longint'(t.p2_c);
        nc  = longint'(t.n2_c);
        avg = (pc + nc) >>> 1;
        td0 = magnitude(pc - nc);
        td1 = (magnitude(longint'(t.prv[15:0]) - c)
              + magnitude(longint'(t.prv[31:16]) - e)) >>> 1;
        td2 = (magnitude(longint'(t.nxt[15:0]) - c)
              + magnitude(longint'(t.nxt[31:16]) - e)) >>> 1;
        tdiff = larger(larger(td0 >>> 1, td1), td2);
        spread = tdiff;
        if (t.kind == ROW_INTERIOR || t.kind == ROW_EDGE_CHECK)
        begin
            bgap = ((pa2 + na2) >>> 1) - c;
            fgap = ((pb2 + nb2) >>> 1) - e;
            dc = avg - c;
            de = avg - e;
            spread = larger(larger(tdiff, smaller(smaller(de, dc), larger(bgap, fgap))),
                            -larger(larger(de, dc), smaller(bgap, fgap)));
        end
        if (t.kind == ROW_INTERIOR)
        begin
            if (magnitude(c - e) > td0)
            begin
                hf = longint'(coefs.hf_center) * (pc + nc)
                   - longint'(coefs.hf_two) * (pa2 + na2 + pb2 + nb2)
                   + longint'(coefs.hf_four) * (pa4 + na4 + pb4 + nb4);
                acc = (hf >>> 2) + longint'(coefs.lf_near) * (c + e)
                    - longint'(coefs.lf_far) * (c3 + e3);
            end
            else
            begin
                acc = longint'(coefs.sp_near) * (c + e) - longint'(coefs.sp_far) * (c3 + e3);
            end
            interp = acc >>> COEF_SHIFT;
        end
        else
        begin
            interp = (c + e) >>> 1;
        end
        if (t.use_edge)
            interp = longint'(t.edge_px);
        interp = smaller(larger(interp, avg - spread), avg + spread);
        if (tdiff == 0)
            interp = avg;
        interp = larger(interp, 0);
        interp = smaller(interp, longint'(peak_reg));
        return interp[LANE_W-1:0];
    endfunction

    function automatic tap_column_t make_column(
        input logic [63:0] p2f, input logic [63:0] n2f,
        input logic [15:0] p2c, input logic [15:0] n2c,
        input logic [31:0] prv, input logic [31:0] nxt, input logic [63:0] cur,
        input logic [15:0] epx, input logic use_e, input logic [1:0] kind);
        tap_column_t t;
        t.p2_far = p2f;
        t.n2_far = n2f;
        t.p2_c = p2c;
        t.n2_c = n2c;
        t.prv = prv;
        t.nxt = nxt;
        t.cur = cur;
        t.edge_px = epx;
        t.use_edge = use_e;
        t.kind = kind;
        return t;
    endfunction

    function automatic logic [15:0] near_pix(input longint base, input longint spread);
        longint v;
        v = base + longint'($urandom_range(32'(2 * spread))) - spread;
        v = smaller(larger(v, 0), 65535);
        return v[15:0];
    endfunction

    function automatic logic [63:0] four_near(input longint base, input longint spread);
        return {near_pix(base, spread), near_pix(base, spread),
                near_pix(base, spread), near_pix(base, spread)};
    endfunction

    function automatic tap_column_t random_column();
        tap_column_t t;
        longint base, spread;
        int mode, k;
        mode = $urandom_range(99);
        if (mode < 20)
        begin
            t.p2_far = {$urandom, $urandom};
            t.n2_far = {$urandom, $urandom};
            t.p2_c = 16'($urandom);
            t.n2_c = 16'($urandom);
            t.prv = $urandom;
            t.nxt = $urandom;
            t.cur = {$urandom, $urandom};
            t.edge_px = 16'($urandom);
        end
        else
        begin
            if (mode < 85)
            begin
                base = longint'($urandom_range(65535));
                case ($urandom_range(4))
                    0: spread = 0;
                    1: spread = 2;
                    2: spread = 16;
                    3: spread = 300;
                    default: spread = 4000;
                endcase
            end
            else
            begin
                base = 127;
                spread = 128;
            end
            t.p2_far = four_near(base, spread);
            t.n2_far = four_near(base, spread);
            t.p2_c = near_pix(base, spread);
            t.n2_c = near_pix(base, spread);
            t.prv = {near_pix(base, spread), near_pix(base, spread)};
            t.nxt = {near_pix(base, spread), near_pix(base, spread)};
            t.cur = four_near(base, spread);
            t.edge_px = ($urandom_range(3) == 0) ? 16'($urandom) : near_pix(base, spread + 64);
        end
        t.use_edge = ($urandom_range(3) == 0);
        k = $urandom_range(9);
        if (k < 5)
            t.kind = ROW_INTERIOR;
        else if (k < 7)
            t.kind = ROW_EDGE_CHECK;
        else if (k < 9)
            t.kind = ROW_EDGE_PLAIN;
        else
            t.kind = 2'b11;
        return t;
    endfunction

    task automatic write_reg(input cfg_reg_t idx, input logic [CFG_DATA_W-1:0] data);
        @(negedge clk);
        cfg_valid <= 1'b1;
        cfg_index <= idx;
        cfg_data  <= data;
        @(posedge clk);
        while (!cfg_ready)
            @(posedge clk);
        case (idx)
            REG_PEAK:      peak_reg = data;
            REG_LF_NEAR:   coefs.lf_near = data[COEF_W-1:0];
            REG_LF_FAR:    coefs.lf_far = data[COEF_W-1:0];
            REG_HF_CENTER: coefs.hf_center = data[COEF_W-1:0];
            REG_HF_TWO:    coefs.hf_two = data[COEF_W-1:0];
            REG_HF_FOUR:   coefs.hf_four = data[COEF_W-1:0];
            REG_SP_NEAR:   coefs.sp_near = data[COEF_W-1:0];
            REG_SP_FAR:    coefs.sp_far = data[COEF_W-1:0];
            default: ;
        endcase
    endtask

    task automatic program_regs(input logic [15:0] pk, input logic [15:0] lfn,
                                input logic [15:0] lff, input logic [15:0] hfc,
                                input logic [15:0] hft, input logic [15:0] hff,
                                input logic [15:0] spn, input logic [15:0] spf);
        write_reg(REG_PEAK, pk);
        write_reg(REG_LF_NEAR, lfn);
        write_reg(REG_LF_FAR, lff);
        write_reg(REG_HF_CENTER, hfc);
        write_reg(REG_HF_TWO, hft);
        write_reg(REG_HF_FOUR, hff);
        write_reg(REG_SP_NEAR, spn);
        write_reg(REG_SP_FAR, spf);
        @(negedge clk);
        cfg_valid <= 1'b0;
        settings_used++;
    endtask

    task automatic drain();
        int waited;
        waited = 0;
        while (column_queue.size() != 0 || start)
            @(posedge clk);
        while (expected_pixels.size() != 0 && waited < DRAIN_LIMIT)
        begin
            @(posedge clk);
            waited++;
        end
        repeat (SETTLE_CYCLES) @(posedge clk);
        if (expected_pixels.size() != 0)
        begin
            report_mismatch($sformatf("%0d pixels never came out", expected_pixels.size()));
            expected_pixels.delete();
        end
    endtask

    // accept a beat and predict its pixel
    always @(posedge clk)
    begin
        beat_taken = rst_n && start && !busy;
        if (beat_taken)
        begin
            expected_pixels.push_back(predict_pixel(column_on_bus));
            columns_sent++;
        end
    end

    always @(negedge clk)
    begin
        if (!rst_n)
        begin
            start <= 1'b0;
        end
        else if (!start || beat_taken)
        begin
            if (column_queue.size() != 0 && $urandom_range(99) >= send_idle_pct)
            begin
                column_on_bus = column_queue.pop_front();
                start          <= 1'b1;
                prev2_far_rows <= column_on_bus.p2_far;
                next2_far_rows <= column_on_bus.n2_far;
                prev2_center   <= column_on_bus.p2_c;
                next2_center   <= column_on_bus.n2_c;
                prev_pair      <= column_on_bus.prv;
                next_pair      <= column_on_bus.nxt;
                cur_rows       <= column_on_bus.cur;
                edge_pixel     <= column_on_bus.edge_px;
                use_edge_pixel <= column_on_bus.use_edge;
                row_kind       <= column_on_bus.kind;
            end
            else
            begin
                start <= 1'b0;
            end
        end
    end

    always @(posedge clk)
    begin
        if (rst_n && out_valid)
        begin
            if (expected_pixels.size() == 0)
            begin
                report_mismatch($sformatf("unexpected out_pixel %h", out_pixel));
            end
            else
            begin
                want = expected_pixels.pop_front();
                pixels_checked++;
                if (out_pixel !== want)
                    report_mismatch($sformatf("out_pixel %h, predicted %h", out_pixel, want));
            end
        end
    end

    initial
    begin
        peak_reg = PEAK_RST;
        coefs.lf_near = LF_NEAR_RST;
        coefs.lf_far = LF_FAR_RST;
        coefs.hf_center = HF_CENTER_RST;
        coefs.hf_two = HF_TWO_RST;
        coefs.hf_four = HF_FOUR_RST;
        coefs.sp_near = SP_NEAR_RST;
        coefs.sp_far = SP_FAR_RST;
        repeat (2) @(posedge clk);
        @(negedge clk);
        rst_n <= 1'b1;

        // reset register values, directed columns
        column_queue.push_back(make_column(0, 0, 0, 0, 0, 0, 0, 0, 1'b0, ROW_INTERIOR));
        column_queue.push_back(make_column('1, '1, '1, '1, '1, '1, '1, '1, 1'b1, 2'b11));
        column_queue.push_back(make_column('1, '1, '1, '1, '1, '1, '1, 0, 1'b0, ROW_INTERIOR));
        column_queue.push_back(make_column({4{16'd100}}, {4{16'd100}}, 100, 100,
            {2{16'd300}}, {2{16'd300}}, {16'd150, 16'd200, 16'd0, 16'd50}, 0, 1'b0,
            ROW_INTERIOR));
        column_queue.push_back(make_column({4{16'd100}}, {4{16'd100}}, 100, 100,
            {2{16'd300}}, {2{16'd300}}, {16'd90, 16'd110, 16'd100, 16'd95}, 0, 1'b0,
            ROW_INTERIOR));
        column_queue.push_back(make_column({4{16'd77}}, {4{16'd77}}, 77, 77,
            {2{16'd77}}, {2{16'd77}}, {4{16'd77}}, 16'd9, 1'b1, ROW_INTERIOR));
        column_queue.push_back(make_column(0, 0, 0, 0, {2{16'd60000}}, {2{16'd60000}},
            64'hFFFF_0000_0000_FFFF, 0, 1'b0, ROW_INTERIOR));
        column_queue.push_back(make_column({4{16'd1000}}, {4{16'd1000}}, 1000, 1000,
            {2{16'd3000}}, {2{16'd3000}}, {4{16'd1000}}, 0, 1'b0, ROW_EDGE_CHECK));
        column_queue.push_back(make_column({4{16'd100}}, {4{16'd100}}, 100, 100,
            {2{16'd300}}, {2{16'd300}}, {16'd150, 16'd200, 16'd0, 16'd50}, 0, 1'b0,
            ROW_EDGE_CHECK));
        column_queue.push_back(make_column({4{16'd100}}, {4{16'd100}}, 100, 100,
            {2{16'd300}}, {2{16'd300}}, {16'd150, 16'd200, 16'd0, 16'd50}, 0, 1'b0,
            ROW_EDGE_PLAIN));
        column_queue.push_back(make_column({4{16'd100}}, {4{16'd100}}, 100, 100,
            {2{16'd300}}, {2{16'd300}}, {16'd150, 16'd200, 16'd0, 16'd50}, 0, 1'b0, 2'b11));
        column_queue.push_back(make_column({4{16'd100}}, {4{16'd100}}, 100, 100,
            {2{16'd300}}, {2{16'd300}}, {16'd150, 16'd200, 16'd0, 16'd50}, 0, 1'b1,
            ROW_INTERIOR));
        column_queue.push_back(make_column({4{16'd100}}, {4{16'd100}}, 100, 100,
            {2{16'd300}}, {2{16'd300}}, {16'd150, 16'd200, 16'd0, 16'd50}, 16'hFFFF, 1'b1,
            ROW_EDGE_CHECK));
        column_queue.push_back(make_column({4{16'hAAAA}}, {4{16'h5555}}, 16'hAAAA, 16'h5555,
            {2{16'hAAAA}}, {2{16'h5555}}, {4{16'hAAAA}}, 16'h5555, 1'b0, ROW_INTERIOR));
        column_queue.push_back(make_column({4{16'h5555}}, {4{16'hAAAA}}, 16'h5555, 16'hAAAA,
            {2{16'h5555}}, {2{16'hAAAA}}, {4{16'h5555}}, 16'hAAAA, 1'b1, ROW_EDGE_PLAIN));
        column_queue.push_back(make_column(0, 0, '1, '1, 0, 0, 0, 0, 1'b0, ROW_INTERIOR));
        drain();

        for (int phase = 0; phase < 6; phase++)
        begin
            send_idle_pct = (phase < 2) ? 21 : (phase < 4) ? 88 : 0;
            case (phase)
                0: program_regs(PEAK_RST, LF_NEAR_RST, LF_FAR_RST, HF_CENTER_RST,
                                HF_TWO_RST, HF_FOUR_RST, SP_NEAR_RST, SP_FAR_RST);
                1: program_regs('1, '1, '1, '1, '1, '1, '1, '1);
                2: program_regs(16'd1, 0, 0, 0, 0, 0, 0, 0);
                3: program_regs(16'($urandom), 16'($urandom), 16'($urandom), 16'($urandom),
                                16'($urandom), 16'($urandom), 16'($urandom), 16'($urandom));
                4: program_regs(16'd0, 16'($urandom), 16'($urandom), 16'($urandom),
                                16'($urandom), 16'($urandom), 16'($urandom), 16'($urandom));
                default: program_regs('1, 16'($urandom), 16'($urandom), 16'($urandom),
                                      16'($urandom), 16'($urandom), 16'($urandom),
                                      16'($urandom));
            endcase
            for (int n = 0; n < PHASE_COLUMNS; n++)
                column_queue.push_back(random_column());
            drain();
        end

        $display("summary: %0d tap columns sent, %0d pixels checked, %0d register settings",
                 columns_sent, pixels_checked, settings_used);
        if (errors == 0)
            $display("tb_top passed");
        else
            $display("tb_top failed");
        $finish;
    end

    initial
    begin
        #(LIMIT_NS);
        $display("timeout with %0d pixels outstanding", expected_pixels.size());
        $display("tb_top failed");
        $finish;
    end

endmodule
